### sv/fsdc_pkg.sv
`timescale 1ns / 1ps

package fsdc_pkg;

  localparam int Side    = 5;
  localparam int Cells   = 25;
  localparam int Letters = 26;

  localparam logic [4:0] LetterJ    = 5'd9;
  localparam logic [4:0] LastLetter = 5'd25;
  localparam logic [4:0] FullCount  = 5'd25;

  localparam logic [7:0] CharUpA = 8'h41;
  localparam logic [7:0] CharUpZ = 8'h5A;
  localparam logic [7:0] CharLoA = 8'h61;
  localparam logic [7:0] CharLoZ = 8'h7A;
  localparam logic [7:0] CharUpI = 8'h49;
  localparam logic [7:0] CharUpJ = 8'h4A;
  localparam logic [7:0] CaseGap = 8'h20;

  localparam logic [1:0] FuncClear = 2'd0;
  localparam logic [1:0] FuncKey   = 2'd1;
  localparam logic [1:0] FuncFill  = 2'd2;
  localparam logic [1:0] FuncPair  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_POS_A,
    S_POS_B,
    S_SQ_A,
    S_SQ_B,
    S_SQ_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       place;
    logic [4:0] place_idx;
    logic [4:0] pos_raddr;
    logic [4:0] sq_raddr;
  } store_req_t;

  typedef struct packed {
    logic [25:0] present;
    logic        full;
  } store_stat_t;

  // Uppercase a-z and fold J into I.
  function automatic logic [7:0] norm_char(input logic [7:0] c);
    logic [7:0] u;
    begin
      u = c;
      if (c >= CharLoA && c <= CharLoZ) begin
        u = c - CaseGap;
      end
      if (u == CharUpJ) begin
        u = CharUpI;
      end
      return u;
    end
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CharUpA) && (c <= CharUpZ);
  endfunction

  function automatic logic [4:0] letter_idx(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = c - CharUpA;
      return d[4:0];
    end
  endfunction

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    begin
      if (p >= 5'd20) begin
        r = 3'd4;
      end else if (p >= 5'd15) begin
        r = 3'd3;
      end else if (p >= 5'd10) begin
        r = 3'd2;
      end else if (p >= 5'd5) begin
        r = 3'd1;
      end else begin
        r = 3'd0;
      end
      return r;
    end
  endfunction

  // Cell in the row of p_row and the column of p_col.
  function automatic logic [4:0] cell_of(input logic [4:0] p_row, input logic [4:0] p_col);
    logic [2:0] r;
    logic [2:0] rc;
    logic [4:0] base_r;
    logic [4:0] base_c;
    logic [4:0] col;
    begin
      r      = row_of(p_row);
      rc     = row_of(p_col);
      base_r = {r, 2'b00} + {2'b00, r};
      base_c = {rc, 2'b00} + {2'b00, rc};
      col    = p_col - base_c;
      return base_r + col;
    end
  endfunction

endpackage

### sv/five_square_digraph_cipher.sv
`timescale 1ns / 1ps

// Clear, keyword, lone character and unmatched pair go from the execute state straight to
// out_strobe; a pair found in the square first takes two position reads and then two
// square reads (memories with one read port each); alphabet completion places one
// letter per cycle first. One request at a time: busy drops the cycle after out_strobe;
// the receiver cannot stall the block. Synchronous active-low reset empties the square;
// stored cells are undefined until placed.
module five_square_digraph_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [7:0] in_first_char,
  input  logic [7:0] in_second_char,
  input  logic       in_second_present,
  output logic       out_strobe,
  output logic [7:0] out_first,
  output logic [7:0] out_second,
  output logic       out_second_valid,
  output logic       out_square_full
);

  fsdc_pkg::state_t      state_r, state_nxt;
  fsdc_pkg::store_req_t  req;
  fsdc_pkg::store_stat_t stat;

  logic [4:0] pos_rdata;
  logic [4:0] sq_rdata;

  logic [1:0] func_r;
  logic [7:0] c1_r;
  logic [7:0] c2_r;
  logic       sp_r;
  logic [4:0] k_r;
  logic [4:0] pa_r;
  logic [4:0] pb_r;
  logic [7:0] o1_r;
  logic [7:0] o2_r;
  logic       valid_r;

  logic [7:0] s_ch;
  logic [7:0] t_ch;
  logic [4:0] ia;
  logic [4:0] ib;
  logic       pair_hit;

  assign s_ch     = fsdc_pkg::norm_char(c1_r);
  assign t_ch     = fsdc_pkg::norm_char(c2_r);
  assign ia       = fsdc_pkg::letter_idx(s_ch);
  assign ib       = fsdc_pkg::letter_idx(t_ch);
  assign pair_hit = fsdc_pkg::is_letter(s_ch) && fsdc_pkg::is_letter(t_ch) &&
                    stat.present[ia] && stat.present[ib];

  fsdc_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .stat      (stat),
    .pos_rdata (pos_rdata),
    .sq_rdata  (sq_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsdc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fsdc_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = fsdc_pkg::S_EXEC;
        end
      end
      fsdc_pkg::S_EXEC: begin
        case (func_r)
          fsdc_pkg::FuncFill: state_nxt = fsdc_pkg::S_FILL;
          fsdc_pkg::FuncPair: state_nxt = (sp_r && pair_hit) ? fsdc_pkg::S_POS_A
                                                              : fsdc_pkg::S_DONE;
          default:            state_nxt = fsdc_pkg::S_DONE;
        endcase
      end
      fsdc_pkg::S_FILL: begin
        if (k_r == fsdc_pkg::LastLetter) begin
          state_nxt = fsdc_pkg::S_DONE;
        end
      end
      fsdc_pkg::S_POS_A:   state_nxt = fsdc_pkg::S_POS_B;
      fsdc_pkg::S_POS_B:   state_nxt = fsdc_pkg::S_SQ_A;
      fsdc_pkg::S_SQ_A:    state_nxt = fsdc_pkg::S_SQ_B;
      fsdc_pkg::S_SQ_B:    state_nxt = fsdc_pkg::S_SQ_LAST;
      fsdc_pkg::S_SQ_LAST: state_nxt = fsdc_pkg::S_DONE;
      fsdc_pkg::S_DONE:    state_nxt = fsdc_pkg::S_IDLE;
      default:             state_nxt = fsdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    case (state_r)
      fsdc_pkg::S_EXEC: begin
        req.clear     = (func_r == fsdc_pkg::FuncClear);
        req.place     = (func_r == fsdc_pkg::FuncKey) && fsdc_pkg::is_letter(s_ch);
        req.place_idx = ia;
      end
      fsdc_pkg::S_FILL: begin
        req.place     = (k_r != fsdc_pkg::LetterJ);
        req.place_idx = k_r;
      end
      fsdc_pkg::S_POS_A: req.pos_raddr = ia;
      fsdc_pkg::S_POS_B: req.pos_raddr = ib;
      // pos_rdata holds the second letter's cell here
      fsdc_pkg::S_SQ_A:  req.sq_raddr = fsdc_pkg::cell_of(pa_r, pos_rdata);
      fsdc_pkg::S_SQ_B:  req.sq_raddr = fsdc_pkg::cell_of(pb_r, pa_r);
      default:           req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      fsdc_pkg::S_IDLE: begin
        if (start) begin
          func_r <= in_func;
          c1_r   <= in_first_char;
          c2_r   <= in_second_char;
          sp_r   <= in_second_present;
        end
      end
      fsdc_pkg::S_EXEC: begin
        k_r     <= '0;
        o1_r    <= '0;
        o2_r    <= '0;
        valid_r <= 1'b0;
        if (func_r == fsdc_pkg::FuncPair) begin
          if (!sp_r) begin
            o1_r <= c1_r;
          end else begin
            o1_r    <= s_ch;
            o2_r    <= t_ch;
            valid_r <= 1'b1;
          end
        end
      end
      fsdc_pkg::S_FILL:    k_r  <= k_r + 5'd1;
      fsdc_pkg::S_POS_B:   pa_r <= pos_rdata;
      fsdc_pkg::S_SQ_A:    pb_r <= pos_rdata;
      fsdc_pkg::S_SQ_B:    o1_r <= fsdc_pkg::CharUpA + {3'b000, sq_rdata};
      fsdc_pkg::S_SQ_LAST: o2_r <= fsdc_pkg::CharUpA + {3'b000, sq_rdata};
      default: begin
      end
    endcase
  end

  assign busy             = (state_r != fsdc_pkg::S_IDLE);
  assign out_strobe       = (state_r == fsdc_pkg::S_DONE);
  assign out_first        = o1_r;
  assign out_second       = o2_r;
  assign out_second_valid = valid_r;
  assign out_square_full  = stat.full;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!out_strobe && !busy))
    else $error("result strobe not followed by idle");

  a_valid_pair_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_second_valid) |-> (func_r == fsdc_pkg::FuncPair && sp_r))
    else $error("second character flagged for a non-pair request");

  a_fill_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsdc_pkg::S_EXEC && func_r == fsdc_pkg::FuncClear) |=> !out_square_full)
    else $error("square still full after clear");
`endif

endmodule

### sv/fsdc_store.sv
`timescale 1ns / 1ps

module fsdc_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsdc_pkg::store_req_t req,
  output fsdc_pkg::store_stat_t stat,
  output logic [4:0]           pos_rdata,
  output logic [4:0]           sq_rdata
);

  logic [25:0] present_r;
  logic [4:0]  fill_r;
  logic [4:0]  sq_mem [fsdc_pkg::Cells];
  logic [4:0]  pos_mem [fsdc_pkg::Letters];
  logic [4:0]  pos_rdata_r;
  logic [4:0]  sq_rdata_r;
  logic        do_place;

  // Skip letters already placed and anything once the square is full.
  assign do_place = req.place && (req.place_idx <= fsdc_pkg::LastLetter) &&
                    !present_r[req.place_idx] && (fill_r < fsdc_pkg::FullCount);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      fill_r    <= '0;
    end else if (req.clear) begin
      present_r <= '0;
      fill_r    <= '0;
    end else if (do_place) begin
      present_r[req.place_idx] <= 1'b1;
      fill_r                   <= fill_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_place) begin
      sq_mem[fill_r]         <= req.place_idx;
      pos_mem[req.place_idx] <= fill_r;
    end
    sq_rdata_r  <= sq_mem[req.sq_raddr];
    pos_rdata_r <= pos_mem[req.pos_raddr];
  end

  assign stat.present = present_r;
  assign stat.full    = (fill_r == fsdc_pkg::FullCount);
  assign pos_rdata    = pos_rdata_r;
  assign sq_rdata     = sq_rdata_r;

endmodule

### bench/five_square_digraph_cipher_tb.sv
`timescale 1ns / 1ps

module five_square_digraph_cipher_tb;

  localparam int CycleLimit  = 200000;
  localparam int SettleLimit = 40;
  localparam int RandomItems = 475;

  typedef struct packed {
    logic [7:0] first_ch;
    logic [7:0] second_ch;
    logic       second_valid;
    logic       square_full;
  } cipher_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_func = fsdc_pkg::FuncClear;
  logic [7:0] in_first_char = 8'h00;
  logic [7:0] in_second_char = 8'h00;
  logic       in_second_present = 1'b0;
  logic       out_strobe;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic       out_second_valid;
  logic       out_square_full;

  // Local copy of the key square
  logic [4:0]  sq_cell [fsdc_pkg::Cells];
  logic [4:0]  letter_cell [fsdc_pkg::Letters];
  logic [25:0] letter_in_square = '0;
  int          cells_used = 0;

  cipher_result_t pending_results[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  requests_sent = 0;
  int  build_count = 0;
  int  pair_count = 0;
  int  square_hit_count = 0;
  int  lone_count = 0;
  bit  idle_on = 1'b1;

  five_square_digraph_cipher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_first_char    (in_first_char),
    .in_second_char   (in_second_char),
    .in_second_present(in_second_present),
    .out_strobe       (out_strobe),
    .out_first        (out_first),
    .out_second       (out_second),
    .out_second_valid (out_second_valid),
    .out_square_full  (out_square_full)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Uppercase a-z, fold J into I
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (u >= fsdc_pkg::CharLoA && u <= fsdc_pkg::CharLoZ) begin
      u = u - fsdc_pkg::CaseGap;
    end
    if (u == fsdc_pkg::CharUpJ) begin
      u = fsdc_pkg::CharUpI;
    end
    return u;
  endfunction

  function automatic int letter_of(input logic [7:0] c);
    if (c >= fsdc_pkg::CharUpA && c <= fsdc_pkg::CharUpZ) begin
      return int'(c - fsdc_pkg::CharUpA);
    end
    return -1;
  endfunction

  function automatic void place_letter(input int idx);
    if (idx < 0 || idx >= fsdc_pkg::Letters || cells_used >= fsdc_pkg::Cells) begin
      return;
    end
    if (letter_in_square[idx[4:0]]) begin
      return;
    end
    sq_cell[cells_used[4:0]] = idx[4:0];
    letter_cell[idx[4:0]] = cells_used[4:0];
    letter_in_square[idx[4:0]] = 1'b1;
    cells_used++;
  endfunction

  function automatic cipher_result_t predict_cipher(input logic [1:0] func,
                                                    input logic [7:0] c1,
                                                    input logic [7:0] c2,
                                                    input logic sp);
    cipher_result_t r;
    logic [7:0] s;
    logic [7:0] t;
    int a;
    int b;
    int p1;
    int p2;
    logic [4:0] cell_a;
    logic [4:0] cell_b;
    r = '0;
    case (func)
      fsdc_pkg::FuncClear: begin
        letter_in_square = '0;
        cells_used = 0;
        build_count++;
      end
      fsdc_pkg::FuncKey: begin
        place_letter(letter_of(fold_char(c1)));
        build_count++;
      end
      fsdc_pkg::FuncFill: begin
        for (int k = 0; k < fsdc_pkg::Letters; k++) begin
          if (k != int'(fsdc_pkg::LetterJ)) begin
            place_letter(k);
          end
        end
        build_count++;
      end
      default: begin
        if (!sp) begin
          r.first_ch = c1;
          lone_count++;
        end else begin
          s = fold_char(c1);
          t = fold_char(c2);
          a = letter_of(s);
          b = letter_of(t);
          r.second_valid = 1'b1;
          pair_count++;
          if (a >= 0 && b >= 0 && letter_in_square[a[4:0]] && letter_in_square[b[4:0]]) begin
            // swap columns between the two rows
            p1 = int'(letter_cell[a[4:0]]);
            p2 = int'(letter_cell[b[4:0]]);
            cell_a = 5'((p1 / fsdc_pkg::Side) * fsdc_pkg::Side + (p2 % fsdc_pkg::Side));
            cell_b = 5'((p2 / fsdc_pkg::Side) * fsdc_pkg::Side + (p1 % fsdc_pkg::Side));
            r.first_ch  = fsdc_pkg::CharUpA + {3'b000, sq_cell[cell_a]};
            r.second_ch = fsdc_pkg::CharUpA + {3'b000, sq_cell[cell_b]};
            square_hit_count++;
          end else begin
            r.first_ch  = s;
            r.second_ch = t;
          end
        end
      end
    endcase
    r.square_full = (cells_used >= fsdc_pkg::Cells);
    return r;
  endfunction

  task automatic send_request(input logic [1:0] func, input logic [7:0] c1,
                              input logic [7:0] c2, input logic sp);
    int gap;
    if (idle_on && $urandom_range(99) < 12) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_func           <= func;
    in_first_char     <= c1;
    in_second_char    <= c2;
    in_second_present <= sp;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_cipher(func, c1, c2, sp));
    requests_sent++;
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] base;
    logic [7:0] ofs;
    base = ($urandom_range(1) == 0) ? fsdc_pkg::CharUpA : fsdc_pkg::CharLoA;
    ofs  = 8'($urandom_range(25));
    return base + ofs;
  endfunction

  // Mostly letters, now and then any byte
  function automatic logic [7:0] random_text_char();
    logic [7:0] c;
    if ($urandom_range(99) < 82) begin
      c = random_letter();
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  always @(posedge clk) begin
    cipher_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: first=%h second=%h valid=%b full=%b",
               out_first, out_second, out_second_valid, out_square_full);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_first !== want.first_ch) begin
          $error("out_first: expected %h, got %h", want.first_ch, out_first);
          mismatches++;
        end
        if (out_second !== want.second_ch) begin
          $error("out_second: expected %h, got %h", want.second_ch, out_second);
          mismatches++;
        end
        if (out_second_valid !== want.second_valid) begin
          $error("out_second_valid: expected %b, got %b", want.second_valid,
                 out_second_valid);
          mismatches++;
        end
        if (out_square_full !== want.square_full) begin
          $error("out_square_full: expected %b, got %b", want.square_full,
                 out_square_full);
          mismatches++;
        end
      end
    end
  end

  // Pairs and lone characters with nothing in the square yet
  task automatic test_unbuilt_square();
    send_request(fsdc_pkg::FuncPair, "a", "j", 1'b1);
    send_request(fsdc_pkg::FuncPair, 8'hFF, 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncPair, 8'h00, 8'hFF, 1'b0);
    send_request(fsdc_pkg::FuncPair, 8'h00, 8'hFF, 1'b1);
  endtask

  // Keyword with case folding, J folding, repeats, non-letters, then fill past full
  task automatic test_keyword_build();
    send_request(fsdc_pkg::FuncClear, 8'hFF, 8'hFF, 1'b1);
    send_request(fsdc_pkg::FuncKey, "p", 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncKey, "L", 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncKey, "a", 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncKey, "y", 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncKey, "J", 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncKey, "i", 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncKey, "3", 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncKey, 8'hFF, 8'hFF, 1'b1);
    send_request(fsdc_pkg::FuncPair, "P", "Z", 1'b1);
    send_request(fsdc_pkg::FuncFill, 8'h00, 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncKey, "Q", 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncFill, 8'hFF, 8'hFF, 1'b1);
  endtask

  task automatic test_pair_rules();
    send_request(fsdc_pkg::FuncPair, "h", "i", 1'b1);
    send_request(fsdc_pkg::FuncPair, "J", "j", 1'b1);
    send_request(fsdc_pkg::FuncPair, "A", "!", 1'b1);
    send_request(fsdc_pkg::FuncPair, "Z", "A", 1'b1);
    send_request(fsdc_pkg::FuncPair, "q", "x", 1'b0);
    send_request(fsdc_pkg::FuncClear, 8'h00, 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncFill, 8'h00, 8'h00, 1'b0);
    send_request(fsdc_pkg::FuncPair, "A", "Y", 1'b1);
  endtask

  // Sessions: clear, keyword, usually fill, then a run of pairs; some noise between
  task automatic test_random_sessions(input int n_items);
    int stop_at;
    int session;
    int key_len;
    int pair_len;
    logic [1:0] f;
    stop_at = requests_sent + n_items;
    session = 0;
    idle_on = 1'b0;
    while (requests_sent < stop_at) begin
      if (requests_sent > stop_at - n_items + 150) begin
        idle_on = 1'b1;
      end
      if ($urandom_range(99) < 8) begin
        f = 2'($urandom_range(3));
        send_request(f, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
      end else begin
        send_request(fsdc_pkg::FuncClear, 8'($urandom_range(255)),
                     8'($urandom_range(255)), 1'($urandom_range(1)));
        key_len = $urandom_range(0, 14);
        repeat (key_len) begin
          send_request(fsdc_pkg::FuncKey, random_text_char(), 8'($urandom_range(255)),
                       1'($urandom_range(1)));
        end
        if ($urandom_range(9) != 0) begin
          send_request(fsdc_pkg::FuncFill, 8'($urandom_range(255)),
                       8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        pair_len = $urandom_range(4, 20);
        repeat (pair_len) begin
          send_request(fsdc_pkg::FuncPair, random_text_char(), random_text_char(),
                       ($urandom_range(9) != 0));
        end
      end
      session++;
      // hold off the sender until the block has answered everything
      if (session % 10 == 5) begin
        wait_results_drained();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_unbuilt_square();
    test_keyword_build();
    test_pair_rules();
    wait_results_drained();
    test_random_sessions(RandomItems);
    wait_results_drained();
    repeat (SettleLimit) @(posedge clk);
    $display("Covered %0d requests: %0d square builds, %0d lone characters,",
             requests_sent, build_count, lone_count);
    $display("  %0d pairs of which %0d were swapped through the square",
             pair_count, square_hit_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
